// ===== rtl/core/sstf_pkg.sv =====
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types and constants of the shortest-seek-time-first disk scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

	// Width and saturation limit of the running total movement.
	localparam int TOTAL_W = 17;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 17'h1FFFF;

	// Operation codes carried on the input tuser.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	// Bit positions of the output tuser flags.
	localparam int OUT_USER_W      = 2;
	localparam int OUT_USER_NO_REQ = 0;
	localparam int OUT_USER_OVF    = 1;

	// Controller states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_FINAL = 5'b01000,
		ST_EMPTY = 5'b10000
	} sstf_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // append the input position to the table
		logic start;       // begin a run from the input position
		logic issue;       // read the next table entry of the scan
		logic finalize;    // serve the best entry and emit its result
		logic emit_empty;  // emit the result of a run with no requests
	} sstf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;   // no requests are loaded
		logic scan_last;    // the entry being issued is the last one
		logic last_served;  // the entry being served ends the run
		logic out_free;     // the output register can take a result
	} sstf_sts_t;

endpackage

// ===== rtl/core/sstf_disk_scheduler.sv =====
// ----------------------------------------------------------------------------
// sstf_disk_scheduler
// Shortest-seek-time-first request scheduler with run statistics.
// ----------------------------------------------------------------------------
// Usage: each transfer on the slave channel carries an operation in s_tuser
// and a cylinder in s_tdata. A load transfer appends a request to a table of
// MAX_REQUESTS entries and produces no result; loads into a full table are
// dropped and raise an overflow flag. A run transfer gives the starting head
// cylinder, and the block then serves every loaded request, always the
// unserved one nearest the head, ties going to the earliest loaded. Each
// served request yields one master transfer with its cylinder, seek distance,
// running total and running maximum; tlast marks the final one. A run with an
// empty table yields a single transfer flagged no_requests.
// Timing: during a run, each result is found by a serial scan that reads one
// table entry per cycle from the table memory, followed by a compare step and
// a serve step. No new transfer is taken until the run has handed its last
// result to the output register.
// Reset empties the table and clears all flags; the table memory itself is
// not cleared. When the receiver stalls, the finished result waits in the
// output register and the next serve step waits for it to be taken.
// ----------------------------------------------------------------------------
module sstf_disk_scheduler #(
	parameter  int MAX_REQUESTS  = 32,
	parameter  int POSITION_BITS = 12,
	localparam int IN_DATA_W     = ((POSITION_BITS + 7) / 8) * 8,
	localparam int OUT_DATA_W    = ((3 * POSITION_BITS + sstf_pkg::TOTAL_W + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Slave channel.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [IN_DATA_W-1:0]            s_tdata,  // position
	input  logic                            s_tuser,  // op (0 load, 1 run)
	// Master channel.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// served_position, seek_distance, total_movement, max_seek
	output logic [OUT_DATA_W-1:0]           m_tdata,
	output logic                            m_tlast,  // last_in_run
	output logic [sstf_pkg::OUT_USER_W-1:0] m_tuser   // no_requests, overflow
);

	sstf_pkg::sstf_cmd_t cmd;
	sstf_pkg::sstf_sts_t sts;

	// The controller sequences loads, scan passes and the hand-off of each
	// result; it sees the handshake, the operation code and the datapath status.
	sstf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_op     (s_tuser),
		.cmd      (cmd),
		.sts      (sts)
	);

	// The datapath owns the table, the search and the output register.
	sstf_datapath #(
		.MAX_REQUESTS  (MAX_REQUESTS),
		.POSITION_BITS (POSITION_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.position (s_tdata[POSITION_BITS-1:0]),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== rtl/core/sstf_ctrl.sv =====
// ----------------------------------------------------------------------------
// sstf_ctrl
// Sequencer of the scheduler: loads, scan passes and result hand-off.
// ----------------------------------------------------------------------------
module sstf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                s_op,
	output sstf_pkg::sstf_cmd_t cmd,
	input  sstf_pkg::sstf_sts_t sts
);

	sstf_pkg::sstf_state_t state_q;
	sstf_pkg::sstf_state_t state_d;
	logic                  accept;

	assign s_tready = (state_q == sstf_pkg::ST_IDLE);
	assign accept   = s_tvalid & s_tready;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		case (state_q)
			sstf_pkg::ST_IDLE: begin
				if (accept) begin
					if (s_op == sstf_pkg::OP_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = sts.count_zero ? sstf_pkg::ST_EMPTY : sstf_pkg::ST_SCAN;
					end
				end
			end
			sstf_pkg::ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.scan_last) begin
					state_d = sstf_pkg::ST_DRAIN;
				end
			end
			sstf_pkg::ST_DRAIN: begin
				state_d = sstf_pkg::ST_FINAL;
			end
			sstf_pkg::ST_FINAL: begin
				if (sts.out_free) begin
					cmd.finalize = 1'b1;
					state_d      = sts.last_served ? sstf_pkg::ST_IDLE : sstf_pkg::ST_SCAN;
				end
			end
			sstf_pkg::ST_EMPTY: begin
				if (sts.out_free) begin
					cmd.emit_empty = 1'b1;
					state_d        = sstf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sstf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sstf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/sstf_datapath.sv =====
// ----------------------------------------------------------------------------
// sstf_datapath
// Request table, serial nearest-entry search, run statistics, output register.
// ----------------------------------------------------------------------------
module sstf_datapath #(
	parameter  int MAX_REQUESTS  = 32,
	parameter  int POSITION_BITS = 12,
	localparam int OUT_DATA_W    = ((3 * POSITION_BITS + sstf_pkg::TOTAL_W + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sstf_pkg::sstf_cmd_t               cmd,
	output sstf_pkg::sstf_sts_t               sts,
	input  logic [POSITION_BITS-1:0]          position,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [OUT_DATA_W-1:0]             m_tdata,
	output logic                              m_tlast,
	output logic [sstf_pkg::OUT_USER_W-1:0]   m_tuser
);

	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int TW    = sstf_pkg::TOTAL_W;
	localparam int SUM_W = (POSITION_BITS + 1 > TW + 1) ? POSITION_BITS + 1 : TW + 1;
	localparam int FLD_W = 3 * POSITION_BITS + TW;

	// Table and bookkeeping.
	logic [POSITION_BITS-1:0] table_mem [MAX_REQUESTS];
	logic [MAX_REQUESTS-1:0]  served_q;
	logic [CNT_W-1:0]         count_q;
	logic                     ovf_q;
	logic                     ovf_run_q;

	// Run state.
	logic [POSITION_BITS-1:0] head_q;
	logic [TW-1:0]            total_q;
	logic [POSITION_BITS-1:0] max_q;
	logic [CNT_W-1:0]         done_q;

	// Scan pipeline: address issue, registered read, compare.
	logic [CNT_W-1:0]         scan_q;
	logic [POSITION_BITS-1:0] rdata_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     vld_s1;
	logic                     found_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic [POSITION_BITS-1:0] best_pos_q;
	logic [POSITION_BITS-1:0] best_d_q;

	// Output register.
	logic                            out_vld_q;
	logic [FLD_W-1:0]                out_data_q;
	logic                            out_last_q;
	logic [sstf_pkg::OUT_USER_W-1:0] out_user_q;

	logic [POSITION_BITS-1:0]        cand_d;
	logic                            better;
	logic [SUM_W-1:0]                sum;
	logic [TW-1:0]                   new_total;
	logic [POSITION_BITS-1:0]        new_max;
	logic [sstf_pkg::OUT_USER_W-1:0] fin_user;
	logic [sstf_pkg::OUT_USER_W-1:0] empty_user;

	assign cand_d = (rdata_s1 >= head_q) ? rdata_s1 - head_q : head_q - rdata_s1;
	assign better = vld_s1 && !served_q[idx_s1] && (!found_q || cand_d < best_d_q);

	assign sum       = SUM_W'(total_q) + SUM_W'(best_d_q);
	assign new_total = (sum > SUM_W'(sstf_pkg::TOTAL_MAX)) ? sstf_pkg::TOTAL_MAX : sum[TW-1:0];
	assign new_max   = (best_d_q > max_q) ? best_d_q : max_q;

	// Flag words of a served result and of an empty run.
	always_comb begin
		fin_user                                = '0;
		fin_user[sstf_pkg::OUT_USER_OVF]        = ovf_run_q;
		empty_user                              = '0;
		empty_user[sstf_pkg::OUT_USER_NO_REQ]   = 1'b1;
	end

	assign sts.count_zero  = (count_q == '0);
	assign sts.scan_last   = (scan_q + CNT_W'(1) == count_q);
	assign sts.last_served = (done_q + CNT_W'(1) == count_q);
	assign sts.out_free    = !out_vld_q || m_tready;

	// Table writes and the registered read port of the scan.
	always_ff @(posedge clk) begin
		if (cmd.load && (count_q < CNT_W'(MAX_REQUESTS))) begin
			table_mem[count_q[IDX_W-1:0]] <= position;
		end
		rdata_s1 <= table_mem[scan_q[IDX_W-1:0]];
		idx_s1   <= scan_q[IDX_W-1:0];
	end

	// Compare payload.
	always_ff @(posedge clk) begin
		if (better) begin
			best_idx_q <= idx_s1;
			best_pos_q <= rdata_s1;
			best_d_q   <= cand_d;
		end
	end

	// Control and run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			served_q  <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			ovf_run_q <= 1'b0;
			head_q    <= '0;
			total_q   <= '0;
			max_q     <= '0;
			done_q    <= '0;
			scan_q    <= '0;
			vld_s1    <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			if (cmd.issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (better) begin
				found_q <= 1'b1;
			end
			if (cmd.load) begin
				if (count_q < CNT_W'(MAX_REQUESTS)) begin
					served_q[count_q[IDX_W-1:0]] <= 1'b0;
					count_q                      <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.start) begin
				head_q    <= position;
				total_q   <= '0;
				max_q     <= '0;
				done_q    <= '0;
				scan_q    <= '0;
				found_q   <= 1'b0;
				ovf_run_q <= ovf_q;
			end
			if (cmd.finalize) begin
				head_q  <= best_pos_q;
				total_q <= new_total;
				max_q   <= new_max;
				done_q  <= done_q + CNT_W'(1);
				scan_q  <= '0;
				found_q <= 1'b0;
			end
			// The end of a run, empty or not, empties the table.
			if ((cmd.finalize && sts.last_served) || cmd.emit_empty) begin
				served_q <= '0;
				count_q  <= '0;
				ovf_q    <= 1'b0;
			end else if (cmd.finalize) begin
				served_q[best_idx_q] <= 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.finalize || cmd.emit_empty) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finalize) begin
			out_data_q <= {new_max, new_total, best_d_q, best_pos_q};
			out_last_q <= sts.last_served;
			out_user_q <= fin_user;
		end else if (cmd.emit_empty) begin
			out_data_q <= '0;
			out_last_q <= 1'b1;
			out_user_q <= empty_user;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_DATA_W'(out_data_q);
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_user_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_REQUESTS))
		else $error("request count exceeds table capacity");

	a_final_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finalize |-> found_q)
		else $error("entry served without a candidate found by the scan");

	a_final_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finalize || cmd.emit_empty) |-> sts.out_free)
		else $error("result written over one still waiting");

	a_run_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finalize && sts.last_served) |=> (count_q == '0) && (served_q == '0))
		else $error("table not emptied at end of run");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (CNT_W'(idx_s1) < count_q))
		else $error("scan read beyond loaded entries");

endmodule

// ===== bench/sstf_disk_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_disk_scheduler_tb
// Self-checking bench for the shortest-seek-time-first disk scheduler.
// Load and run transfers are sent on the slave channel. A behavioral schedule
// model builds the serve order of every run from the same transfers, and
// each master transfer is compared field by field with the oldest predicted
// serve. Both channels idle at random. One phase stalls the receiver long
// enough to back the block up into its input.
// ----------------------------------------------------------------------------
module sstf_disk_scheduler_tb;

	localparam int MAX_REQ      = 32;
	localparam int POS_W        = 12;
	localparam int IN_W         = 16;
	localparam int OUT_W        = 56;
	localparam int RANDOM_ITEMS = 350;

	// Bit offsets of the result fields inside m_tdata, lowest field first.
	localparam int SERVED_LSB = 0;
	localparam int SEEK_LSB   = SERVED_LSB + POS_W;
	localparam int TOTAL_LSB  = SEEK_LSB + POS_W;
	localparam int PEAK_LSB   = TOTAL_LSB + sstf_pkg::TOTAL_W;

	// One predicted serve, in the same terms as a master transfer.
	typedef struct packed {
		logic [POS_W-1:0]             served_position;
		logic [POS_W-1:0]             seek_distance;
		logic [sstf_pkg::TOTAL_W-1:0] total_movement;
		logic [POS_W-1:0]             max_seek;
		logic                         last_in_run;
		logic                         no_requests;
		logic                         overflow;
	} serve_result_t;

	logic             clk;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;  // position
	logic             s_tuser  = sstf_pkg::OP_LOAD;  // op (0 load, 1 run)
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	// served_position, seek_distance, total_movement, max_seek
	logic [OUT_W-1:0] m_tdata;
	logic             m_tlast;  // last_in_run
	logic [sstf_pkg::OUT_USER_W-1:0] m_tuser;  // no_requests, overflow

	// Predicted serves still waiting for their master transfer.
	serve_result_t serve_queue[$];
	serve_result_t want;

	// Private copy of the request table, kept by the schedule model.
	logic [POS_W-1:0] queued_cyl [MAX_REQ];
	int               queued_count = 0;
	logic             drop_seen    = 1'b0;

	// Shared knobs: quiet turns random idling off on both channels, and
	// hold_cycles makes the receiver refuse transfers until it counts down to zero.
	bit               quiet        = 1'b0;
	int               hold_cycles  = 0;
	int               fail_count   = 0;
	logic [POS_W-1:0] cluster_base = '0;
	int               drain_wait;

	sstf_disk_scheduler #(
		.MAX_REQUESTS  (MAX_REQ),
		.POSITION_BITS (POS_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Schedule model. A load appends to the table or, once the table is full,
	// only records the drop. A run serves every loaded request in
	// nearest-first order; the strict less-than compare over ascending
	// indexes gives ties to the earliest loaded entry. The table empties
	// after every run, an empty one included.
	task automatic predict_schedule(input logic op, input logic [POS_W-1:0] cyl);
		serve_result_t              res;
		logic                       served [MAX_REQ];
		logic [POS_W-1:0]           head;
		logic [sstf_pkg::TOTAL_W:0] total;
		int                         peak;
		int                         best;
		int                         best_d;
		int                         d;
		int                         k;
		int                         j;
		if (op == sstf_pkg::OP_LOAD) begin
			if (queued_count < MAX_REQ) begin
				queued_cyl[queued_count] = cyl;
				queued_count++;
			end else begin
				drop_seen = 1'b1;
			end
			return;
		end
		res = '0;
		if (queued_count == 0) begin
			// An empty run reports only the two flags.
			res.last_in_run = 1'b1;
			res.no_requests = 1'b1;
			serve_queue = {serve_queue, res};
		end else begin
			for (j = 0; j < MAX_REQ; j++) served[j] = 1'b0;
			head  = cyl;
			total = '0;
			peak  = 0;
			for (k = 0; k < queued_count; k++) begin
				best   = -1;
				best_d = 0;
				for (j = 0; j < queued_count; j++) begin
					if (!served[j]) begin
						if (queued_cyl[j] >= head) d = int'(queued_cyl[j]) - int'(head);
						else d = int'(head) - int'(queued_cyl[j]);
						if (best < 0 || d < best_d) begin
							best   = j;
							best_d = d;
						end
					end
				end
				served[best] = 1'b1;
				// The total saturates, although the default sizes never get there.
				total = total + best_d;
				if (total > sstf_pkg::TOTAL_MAX) total = sstf_pkg::TOTAL_MAX;
				if (best_d > peak) peak = best_d;
				head = queued_cyl[best];
				res.served_position = head;
				res.seek_distance   = best_d[POS_W-1:0];
				res.total_movement  = total[sstf_pkg::TOTAL_W-1:0];
				res.max_seek        = peak[POS_W-1:0];
				res.last_in_run     = (k == queued_count - 1);
				res.no_requests     = 1'b0;
				res.overflow        = drop_seen;
				serve_queue = {serve_queue, res};
			end
		end
		queued_count = 0;
		drop_seen    = 1'b0;
	endtask

	// Random cylinder: the two extremes, a tight cluster that makes ties and
	// equal distances likely, or anything at all.
	function automatic logic [POS_W-1:0] rand_cylinder();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10) return '0;
		if (pick < 20) return '1;
		if (pick < 40) return POS_W'(int'(cluster_base) + $urandom_range(0, 6));
		return POS_W'($urandom);
	endfunction

	// Sends one slave transfer. It is entered and left just after a falling
	// edge. On return tvalid is still high with the accepted item, so the
	// caller must drive tvalid again in that same step, either with the next
	// item or low, and never both.
	task automatic send_item(input logic op, input logic [POS_W-1:0] cyl);
		while (!quiet && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= IN_W'(cyl);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_schedule(op, cyl);
		@(negedge clk);
	endtask

	// Lowers tvalid and holds the sender back until every predicted serve
	// has come out.
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (serve_queue.size() != 0) @(negedge clk);
	endtask

	// Receiver. tready changes only at the falling edge. A requested hold-off
	// is counted down here, one cycle per falling edge.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else if (quiet) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 24);
			end
		end
	end

	task automatic compare_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	// Checker. Every accepted master transfer is matched against the oldest
	// predicted serve. The outputs are read at the rising edge, before the
	// block updates its registers for that edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (serve_queue.size() == 0) begin
				$error("unexpected result transfer: served_position %0d",
					m_tdata[SERVED_LSB +: POS_W]);
				fail_count++;
			end else begin
				want = serve_queue.pop_front();
				compare_field("served_position", want.served_position,
					m_tdata[SERVED_LSB +: POS_W]);
				compare_field("seek_distance", want.seek_distance,
					m_tdata[SEEK_LSB +: POS_W]);
				compare_field("total_movement", want.total_movement,
					m_tdata[TOTAL_LSB +: sstf_pkg::TOTAL_W]);
				compare_field("max_seek", want.max_seek, m_tdata[PEAK_LSB +: POS_W]);
				compare_field("last_in_run", want.last_in_run, m_tlast);
				compare_field("no_requests", want.no_requests,
					m_tuser[sstf_pkg::OUT_USER_NO_REQ]);
				compare_field("overflow", want.overflow, m_tuser[sstf_pkg::OUT_USER_OVF]);
			end
		end
	end

	// A run right out of reset finds an empty table.
	task automatic test_empty_run();
		send_item(sstf_pkg::OP_RUN, '0);
		wait_drain();
	endtask

	// Full-stroke seeks in both directions give the largest distance.
	task automatic test_extreme_seeks();
		send_item(sstf_pkg::OP_LOAD, '1);
		send_item(sstf_pkg::OP_RUN, '0);
		send_item(sstf_pkg::OP_LOAD, '0);
		send_item(sstf_pkg::OP_RUN, '1);
		wait_drain();
	endtask

	// With the head on 200, the requests on 100 and 300 are equally far, and
	// 300 is also loaded twice. The earliest loaded entry must win each tie,
	// and the duplicate must be served at a seek distance of zero.
	task automatic test_tie_break();
		send_item(sstf_pkg::OP_LOAD, 12'd100);
		send_item(sstf_pkg::OP_LOAD, 12'd300);
		send_item(sstf_pkg::OP_LOAD, 12'd300);
		send_item(sstf_pkg::OP_LOAD, 12'd200);
		send_item(sstf_pkg::OP_RUN, 12'd200);
		wait_drain();
	endtask

	// Alternating bit patterns on both load and run, then a second run that
	// finds the table already cleared.
	task automatic test_bit_patterns();
		send_item(sstf_pkg::OP_LOAD, 12'hAAA);
		send_item(sstf_pkg::OP_LOAD, 12'h555);
		send_item(sstf_pkg::OP_RUN, 12'hFFF);
		send_item(sstf_pkg::OP_RUN, 12'hAAA);
		wait_drain();
	endtask

	// The receiver holds off for a long stretch while the sender overfills
	// the table and starts a run. The finished result sits in the output
	// register, the run stalls, and the next transfers wait on s_tready.
	// The dropped loads must show up as overflow on every result of that run
	// only, and a later empty run must report no overflow.
	task automatic test_overflow_backpressure();
		int i;
		hold_cycles = 600;
		for (i = 0; i < MAX_REQ + 2; i++) send_item(sstf_pkg::OP_LOAD, rand_cylinder());
		send_item(sstf_pkg::OP_RUN, 12'd2048);
		for (i = 0; i < 3; i++) send_item(sstf_pkg::OP_LOAD, rand_cylinder());
		send_item(sstf_pkg::OP_RUN, '0);
		wait_drain();
		send_item(sstf_pkg::OP_RUN, '1);
		wait_drain();
	endtask

	// Mostly well-formed bursts of loads closed by a run, with some bursts
	// large enough to overflow, and a share of stray single transfers. A
	// middle stretch runs with no idling on either channel.
	task automatic test_random_traffic();
		int sent;
		int burst;
		int i;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			quiet = (sent >= 150 && sent < 240);
			cluster_base = POS_W'($urandom_range(0, 4089));
			if ($urandom_range(99) < 85) begin
				if ($urandom_range(9) == 0) burst = $urandom_range(9, 40);
				else burst = $urandom_range(0, 8);
				for (i = 0; i < burst; i++) send_item(sstf_pkg::OP_LOAD, rand_cylinder());
				send_item(sstf_pkg::OP_RUN, rand_cylinder());
				sent += burst + 1;
			end else begin
				send_item(1'($urandom_range(1)), rand_cylinder());
				sent++;
			end
		end
		quiet = 1'b0;
		wait_drain();
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_run();
		test_extreme_seeks();
		test_tie_break();
		test_bit_patterns();
		test_overflow_backpressure();
		test_random_traffic();

		// Let the block settle, then make sure nothing stray comes out.
		for (drain_wait = 0; drain_wait < 100000 && serve_queue.size() != 0; drain_wait++)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (serve_queue.size() != 0) begin
			$error("%0d predicted results never arrived", serve_queue.size());
			fail_count++;
		end

		if (fail_count == 0) begin
			$display("sstf_disk_scheduler_tb passed");
		end else begin
			$display("sstf_disk_scheduler_tb failed");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("sstf_disk_scheduler_tb failed");
		$finish;
	end

endmodule
